// File: rtl/tcc_pkg.sv
// Package: shared types and register/opcode constants for the timer/counter channel.
`default_nettype none
package tcc_pkg;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned OFS_W  = 6;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ERR_W  = 2;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned STAT_W = 17;

  // Item kinds
  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_OK      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_OFFSET  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_CAPTURE = 2'd2;
  localparam logic [ERR_W-1:0] ERR_BURST   = 2'd3;

  // Register byte offsets
  localparam logic [OFS_W-1:0] OFS_CCR = 6'h00;
  localparam logic [OFS_W-1:0] OFS_CMR = 6'h04;
  localparam logic [OFS_W-1:0] OFS_CV  = 6'h10;
  localparam logic [OFS_W-1:0] OFS_RA  = 6'h14;
  localparam logic [OFS_W-1:0] OFS_RB  = 6'h18;
  localparam logic [OFS_W-1:0] OFS_RC  = 6'h1C;
  localparam logic [OFS_W-1:0] OFS_SR  = 6'h20;
  localparam logic [OFS_W-1:0] OFS_IER = 6'h24;
  localparam logic [OFS_W-1:0] OFS_IDR = 6'h28;
  localparam logic [OFS_W-1:0] OFS_IMR = 6'h2C;

  // Status bit positions
  localparam int unsigned ST_COVFS  = 0;
  localparam int unsigned ST_CPAS   = 2;
  localparam int unsigned ST_CPBS   = 3;
  localparam int unsigned ST_CPCS   = 4;
  localparam int unsigned ST_CLKSTA = 16;
  localparam int unsigned EVT_W     = 8;

  // Mode register bit positions
  localparam int unsigned MD_WAVE    = 15;
  localparam int unsigned MD_WAVSEL  = 13;
  localparam int unsigned MD_CPCTRG  = 14;
  localparam int unsigned MD_CPCSTOP = 6;
  localparam int unsigned MD_CPCDIS  = 7;
  localparam int unsigned MD_BURST   = 4;

  // Control register bits
  localparam int unsigned CTL_ENA = 0;
  localparam int unsigned CTL_DIS = 1;
  localparam int unsigned CTL_TRG = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [OFS_W-1:0]  offset;
    logic [DATA_W-1:0] wdata;
  } tcc_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] rdata;
    logic              irq;
    logic [ERR_W-1:0]  error;
  } tcc_result_t;

endpackage
`default_nettype wire

// File: rtl/tcc_chan_if.sv
// Interfaces: valid/ready channels for input items and result items.
`default_nettype none
interface tcc_in_if;
  logic                         valid;
  logic                         ready;
  logic [tcc_pkg::OP_W-1:0]     op;
  logic [tcc_pkg::OFS_W-1:0]    offset;
  logic [tcc_pkg::DATA_W-1:0]   wdata;

  modport source (output valid, op, offset, wdata, input ready);
  modport sink   (input valid, op, offset, wdata, output ready);
endinterface

interface tcc_out_if;
  logic                         valid;
  logic                         ready;
  logic [tcc_pkg::DATA_W-1:0]   rdata;
  logic                         irq;
  logic [tcc_pkg::ERR_W-1:0]    error;

  modport source (output valid, rdata, irq, error, input ready);
  modport sink   (input valid, rdata, irq, error, output ready);
endinterface
`default_nettype wire

// File: rtl/tcc_chan_logic.sv
// Channel state registers and the single-pass update logic for one item.
`default_nettype none
module tcc_chan_logic (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                go,
  input  wire tcc_pkg::tcc_item_t  item,
  output tcc_pkg::tcc_result_t     result
);
  import tcc_pkg::*;

  logic [DATA_W-1:0] mode_r, mode_nxt;
  logic [CNT_W-1:0]  cv_r, cv_nxt;
  logic [DATA_W-1:0] ra_r, ra_nxt;
  logic [DATA_W-1:0] rb_r, rb_nxt;
  logic [CNT_W-1:0]  rc_r, rc_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [DATA_W-1:0] mask_r, mask_nxt;
  logic              down_r, down_nxt;
  logic              run_r, run_nxt;

  always_comb begin
    logic [1:0]       wsel;
    logic [CNT_W-1:0] top;
    logic             dn;
    logic             wave;
    wsel       = mode_r[MD_WAVSEL +: 2];
    wave       = mode_r[MD_WAVE];
    top        = wsel[1] ? rc_r : CNT_MAX;
    dn         = down_r;
    mode_nxt   = mode_r;
    cv_nxt     = cv_r;
    ra_nxt     = ra_r;
    rb_nxt     = rb_r;
    rc_nxt     = rc_r;
    status_nxt = status_r;
    mask_nxt   = mask_r;
    down_nxt   = down_r;
    run_nxt    = run_r;
    result     = '0;

    if (go) begin
      case (item.op)
        OP_READ: begin
          case (item.offset)
            OFS_CMR: result.rdata = mode_r;
            OFS_CV:  result.rdata = {{(DATA_W-CNT_W){1'b0}}, cv_r};
            OFS_RA:  result.rdata = ra_r;
            OFS_RB:  result.rdata = rb_r;
            OFS_RC:  result.rdata = {{(DATA_W-CNT_W){1'b0}}, rc_r};
            OFS_SR: begin
              // Return the events, then drop them
              result.rdata = {{(DATA_W-STAT_W){1'b0}}, status_r};
              status_nxt[EVT_W-1:0] = '0;
            end
            OFS_IMR: result.rdata = mask_r;
            default: result.error = ERR_OFFSET;
          endcase
        end
        OP_WRITE: begin
          case (item.offset)
            OFS_CCR: begin
              if (item.wdata[CTL_ENA] && !item.wdata[CTL_DIS]) begin
                status_nxt[ST_CLKSTA] = 1'b1;
              end
              if (item.wdata[CTL_DIS]) begin
                status_nxt[ST_CLKSTA] = 1'b0;
                run_nxt = 1'b0;
              end
              if (item.wdata[CTL_TRG]) begin
                // Software trigger: flip triangle direction or restart count
                if (wave && wsel[0]) begin
                  down_nxt = !down_r;
                end else begin
                  cv_nxt = '0;
                end
                if (status_nxt[ST_CLKSTA]) begin
                  run_nxt = 1'b1;
                end
              end
            end
            OFS_CMR: begin
              if (item.wdata[MD_BURST +: 2] != 2'b00) begin
                result.error = ERR_BURST;
              end else begin
                mode_nxt = item.wdata;
              end
            end
            OFS_RA: begin
              if (!wave) result.error = ERR_CAPTURE;
              else ra_nxt = item.wdata;
            end
            OFS_RB: begin
              if (!wave) result.error = ERR_CAPTURE;
              else rb_nxt = item.wdata;
            end
            OFS_RC:  rc_nxt = item.wdata[CNT_W-1:0];
            OFS_IER: mask_nxt = mask_r | item.wdata;
            OFS_IDR: mask_nxt = mask_r & ~item.wdata;
            default: result.error = ERR_OFFSET;
          endcase
        end
        OP_TICK: begin
          if (run_r) begin
            if (cv_r == CNT_MAX) status_nxt[ST_COVFS] = 1'b1;
            if (wave) begin
              if (!wsel[0]) begin
                cv_nxt = (cv_r == top) ? '0 : cv_r + 1'b1;
              end else begin
                if (cv_r == top) dn = 1'b1;
                else if (cv_r == '0) dn = 1'b0;
                down_nxt = dn;
                cv_nxt   = dn ? cv_r - 1'b1 : cv_r + 1'b1;
              end
              if (ra_r == {{(DATA_W-CNT_W){1'b0}}, cv_nxt}) status_nxt[ST_CPAS] = 1'b1;
              if (rb_r == {{(DATA_W-CNT_W){1'b0}}, cv_nxt}) status_nxt[ST_CPBS] = 1'b1;
              if (rc_r == cv_nxt) begin
                status_nxt[ST_CPCS] = 1'b1;
                if (mode_r[MD_CPCDIS]) begin
                  status_nxt[ST_CLKSTA] = 1'b0;
                  run_nxt = 1'b0;
                end
                if (mode_r[MD_CPCSTOP]) run_nxt = 1'b0;
              end
            end else begin
              cv_nxt = cv_r + 1'b1;
              if (rc_r == cv_nxt) begin
                status_nxt[ST_CPCS] = 1'b1;
                if (mode_r[MD_CPCTRG]) cv_nxt = '0;
              end
            end
          end
        end
        default: ;
      endcase
    end

    result.irq = |(status_nxt[EVT_W-1:0] & mask_nxt[EVT_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= '0;
      cv_r     <= '0;
      ra_r     <= '0;
      rb_r     <= '0;
      rc_r     <= '0;
      status_r <= '0;
      mask_r   <= '0;
      down_r   <= 1'b0;
      run_r    <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      cv_r     <= cv_nxt;
      ra_r     <= ra_nxt;
      rb_r     <= rb_nxt;
      rc_r     <= rc_nxt;
      status_r <= status_nxt;
      mask_r   <= mask_nxt;
      down_r   <= down_nxt;
      run_r    <= run_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/timer_counter_channel_core.sv
// Top level: one 16-bit timer/counter channel with input and result registers.
`default_nettype none
// One 16-bit timer/counter channel driven by items: each input item is a
// register read, a register write or one counter clock tick, and each item
// gives exactly one result item (read data, interrupt level, error code).
// An accepted item lands in an input register; once the result register is
// free or being drained, the channel logic updates the counter, compare and
// status registers and the result is captured in an output register. The
// block sustains one item per cycle as long as the output side keeps taking
// results. The throughput is set by the single state-update step. The input
// side keeps accepting while a result waits as long as the input register is
// empty, or its item can move into a result register that is free or being
// drained in the same cycle.
// Reset is synchronous, active low, and clears all channel registers.
module timer_counter_channel_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tcc_in_if.sink     in_ch,
  tcc_out_if.source  out_ch
);
  import tcc_pkg::*;

  tcc_item_t   item_r;
  logic        item_valid_r, item_valid_nxt;
  tcc_result_t res_r;
  tcc_result_t res_comb;
  logic        res_valid_r, res_valid_nxt;
  logic        advance;
  logic        in_take;

  // Advance the held item when the result register is free or draining
  assign advance = item_valid_r && (!res_valid_r || out_ch.ready);
  assign in_ch.ready = !item_valid_r || advance;
  assign in_take = in_ch.valid && in_ch.ready;

  assign item_valid_nxt = in_take ? 1'b1 : (advance ? 1'b0 : item_valid_r);
  assign res_valid_nxt  = advance ? 1'b1 :
                          ((res_valid_r && out_ch.ready) ? 1'b0 : res_valid_r);

  tcc_chan_logic u_logic (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (advance),
    .item   (item_r),
    .result (res_comb)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      res_valid_r  <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
      res_valid_r  <= res_valid_nxt;
    end
  end

  // Payload registers: hold unless a new item or result is loaded
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.op     <= in_ch.op;
      item_r.offset <= in_ch.offset;
      item_r.wdata  <= in_ch.wdata;
    end
    if (advance) begin
      res_r <= res_comb;
    end
  end

  assign out_ch.valid = res_valid_r;
  assign out_ch.rdata = res_r.rdata;
  assign out_ch.irq   = res_r.irq;
  assign out_ch.error = res_r.error;

endmodule
`default_nettype wire
